/* hdl/tgi_pkg.sv */
// Package for the turtle graphics interpreter: payload structs, codes,
// CORDIC constants and the queue entry type. No dependencies.
`default_nettype none
package tgi_pkg;

    localparam int STACK_DEPTH_DEF = 4096;
    localparam int NODE_ID_BITS_DEF = 20;
    localparam int MAX_SEG_DEF = 3;
    localparam int CORDIC_STEPS = 16;
    localparam int ID_W = 20;
    localparam int ADDR_W = 4;

    localparam logic [3:0] K_RESTART = 4'd0;
    localparam logic [3:0] K_DRAW = 4'd1;
    localparam logic [3:0] K_MOVE = 4'd2;
    localparam logic [3:0] K_TURN_CCW = 4'd3;
    localparam logic [3:0] K_TURN_CW = 4'd4;
    localparam logic [3:0] K_THIN = 4'd5;
    localparam logic [3:0] K_WIDE = 4'd6;
    localparam logic [3:0] K_PUSH = 4'd7;
    localparam logic [3:0] K_POP = 4'd8;
    localparam logic [3:0] K_NOP = 4'd9;

    localparam logic [1:0] E_OK = 2'd0;
    localparam logic [1:0] E_OVER = 2'd1;
    localparam logic [1:0] E_UNDER = 2'd2;

    localparam logic [1:0] R_START_X = 2'd0;
    localparam logic [1:0] R_START_Y = 2'd1;
    localparam logic [1:0] R_START_HD = 2'd2;
    localparam logic [1:0] R_NPS = 2'd3;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] amount;
    } t_in;

    typedef struct packed {
        logic [1:0]         error_code;
        logic               node_valid;
        logic [ID_W-1:0]    node_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic signed [31:0] line_width;
        logic               segment_valid;
        logic [ID_W-1:0]    seg_node_first;
        logic [ID_W-1:0]    seg_node_second;
        logic [ID_W-1:0]    seg_node_third;
    } t_out;

    // classified op in the queue
    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] amount;
        logic               is_move;
    } t_op;

    function automatic logic [30:0] arctan(input logic [3:0] i);
        case (i)
            4'd0: arctan = 31'd536870912;
            4'd1: arctan = 31'd316933406;
            4'd2: arctan = 31'd167458907;
            4'd3: arctan = 31'd85004756;
            4'd4: arctan = 31'd42667331;
            4'd5: arctan = 31'd21354465;
            4'd6: arctan = 31'd10680862;
            4'd7: arctan = 31'd5340245;
            4'd8: arctan = 31'd2670163;
            4'd9: arctan = 31'd1335087;
            4'd10: arctan = 31'd667544;
            4'd11: arctan = 31'd333772;
            4'd12: arctan = 31'd166886;
            4'd13: arctan = 31'd83443;
            4'd14: arctan = 31'd41722;
            default: arctan = 31'd20861;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/tgi_front.sv */
// Front end: accepts input words, tags moves, and holds a two-entry queue.
// Depends on tgi_pkg.
`default_nettype none
module tgi_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tgi_pkg::t_in  i_data,
    output logic               o_q_valid,
    output tgi_pkg::t_op       o_q_op,
    input  wire logic          i_q_pop
);
    tgi_pkg::t_op r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    tgi_pkg::t_op w_op;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_op = r_mem[r_rp];

    always_comb begin
        w_op.kind = i_data.kind;
        w_op.amount = i_data.amount;
        w_op.is_move = (i_data.kind == tgi_pkg::K_DRAW) || (i_data.kind == tgi_pkg::K_MOVE);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_op;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/tgi_cordic.sv */
// Iterative 16-step CORDIC giving cos and sin (Q4.30) of a Q0.32 heading.
// Depends on tgi_pkg.
`default_nettype none
module tgi_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_heading,
    output logic                    o_done,
    output logic signed [33:0]      o_cos,
    output logic signed [33:0]      o_sin
);
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic [1:0]         r_q;
    logic [3:0]         r_i;
    logic               r_busy;
    logic signed [33:0] w_xs, w_ys;
    logic signed [32:0] w_at;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed({2'b00, tgi_pkg::arctan(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i <= 4'd0;
                r_x <= tgi_pkg::CORDIC_START;
                r_y <= '0;
                r_z <= $signed({3'b000, i_heading[29:0]});
                r_q <= i_heading[31:30];
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0: begin o_cos = r_x; o_sin = r_y; end
            2'd1: begin o_cos = -r_y; o_sin = r_x; end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end
endmodule
`default_nettype wire

/* hdl/tgi_back.sv */
// Back end: turtle state, state stack memory and result register.
// Depends on tgi_pkg and tgi_cordic.
`default_nettype none
module tgi_back #(
    parameter int STACK_DEPTH = tgi_pkg::STACK_DEPTH_DEF,
    parameter int NODE_ID_BITS = tgi_pkg::NODE_ID_BITS_DEF,
    parameter int MAX_SEG = tgi_pkg::MAX_SEG_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire tgi_pkg::t_op       i_q_op,
    output logic                    o_q_pop,
    input  wire logic signed [31:0] i_start_x,
    input  wire logic signed [31:0] i_start_y,
    input  wire logic [31:0]        i_start_hd,
    input  wire logic [1:0]         i_nps,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output tgi_pkg::t_out           o_data,
    output logic                    o_idle
);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENTRY_W = 32 * 4 + 3 * NODE_ID_BITS + 2;
    localparam logic [SP_W-1:0] DEPTH_V = SP_W'(STACK_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_MUL, S_ADD, S_POPRD, S_OUT} t_state;

    t_state r_state;
    tgi_pkg::t_op r_op;
    logic signed [31:0] r_x, r_y, r_w;
    logic [31:0] r_hd;
    logic [NODE_ID_BITS-1:0] r_ring [3];
    logic [1:0] r_head, r_seen;
    logic [NODE_ID_BITS-1:0] r_next;
    logic [SP_W-1:0] r_sp;
    logic [ENTRY_W-1:0] r_stack [STACK_DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic signed [65:0] r_px, r_py;
    logic [1:0] r_err;
    logic r_node_v, r_seg_v;
    logic [tgi_pkg::ID_W-1:0] r_node_id;
    logic [tgi_pkg::ID_W-1:0] r_seg [3];

    logic cs_start, cs_done;
    logic signed [33:0] cs_cos, cs_sin;

    tgi_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cs_start), .i_heading(r_hd),
        .o_done(cs_done), .o_cos(cs_cos), .o_sin(cs_sin)
    );

    logic [1:0] w_n;
    always_comb begin
        w_n = i_nps;
        if (w_n == 2'd0) w_n = 2'd1;
        if (32'(w_n) > MAX_SEG) w_n = 2'(MAX_SEG);
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign cs_start = o_q_pop && i_q_op.is_move;
    assign o_idle = (r_state == S_IDLE) && !o_valid;

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat = 32'sh7fffffff;
        else if (v < -34'sd2147483648) sat = 32'sh80000000;
        else sat = v[31:0];
    endfunction

    // small remainder of a value 0..5 by a count 1..3
    function automatic logic [1:0] mod_n(input logic [2:0] a, input logic [1:0] n);
        case (n)
            2'd1: mod_n = 2'd0;
            2'd2: mod_n = {1'b0, a[0]};
            default: mod_n = (a >= 3'd3) ? 2'(a - 3'd3) : a[1:0];
        endcase
    endfunction

    logic signed [65:0] w_rx, w_ry;
    assign w_rx = (r_px + 66'sd536870912) >>> 30;
    assign w_ry = (r_py + 66'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_q_op.kind == tgi_pkg::K_PUSH
            && r_sp < DEPTH_V) begin
            r_stack[r_sp[SA_W-1:0]] <= {r_x, r_y, r_hd, r_w, r_ring[0], r_ring[1],
                                         r_ring[2], r_head};
        end
        r_rd <= r_stack[SA_W'(r_sp - SP_W'(1))];
    end

    always_ff @(posedge i_clk) begin
        logic [NODE_ID_BITS-1:0] id;
        logic [1:0] hd2;
        logic [1:0] seen2;
        logic [1:0] slot;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_x <= '0; r_y <= '0; r_hd <= '0; r_w <= '0;
            r_ring[0] <= '0; r_ring[1] <= '0; r_ring[2] <= '0;
            r_head <= '0; r_seen <= '0; r_next <= '0; r_sp <= '0;
            r_err <= tgi_pkg::E_OK; r_node_v <= 1'b0; r_node_id <= '0; r_seg_v <= 1'b0;
            r_seg[0] <= '0; r_seg[1] <= '0; r_seg[2] <= '0;
        end else begin
            if (r_state == S_OUT && (!o_valid || !i_stall)) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op <= i_q_op;
                        r_node_v <= (i_q_op.kind == tgi_pkg::K_RESTART);
                        r_node_id <= '0;
                        r_seg_v <= 1'b0;
                        r_seg[0] <= '0; r_seg[1] <= '0; r_seg[2] <= '0;
                        if (i_q_op.kind == tgi_pkg::K_PUSH && r_sp >= DEPTH_V)
                            r_err <= tgi_pkg::E_OVER;
                        else if (i_q_op.kind == tgi_pkg::K_POP && r_sp == '0)
                            r_err <= tgi_pkg::E_UNDER;
                        else
                            r_err <= tgi_pkg::E_OK;
                        case (i_q_op.kind)
                            tgi_pkg::K_RESTART: begin
                                r_x <= i_start_x; r_y <= i_start_y;
                                r_hd <= i_start_hd; r_w <= '0;
                                r_ring[0] <= '0; r_ring[1] <= '0; r_ring[2] <= '0;
                                r_head <= mod_n(3'd1, w_n);
                                r_seen <= 2'd1;
                                r_sp <= '0;
                                r_next <= NODE_ID_BITS'(1);
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_DRAW, tgi_pkg::K_MOVE: r_state <= S_CORDIC;
                            tgi_pkg::K_TURN_CCW: begin
                                r_hd <= r_hd - {i_q_op.amount[16:0], 15'd0};
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_TURN_CW: begin
                                r_hd <= r_hd + {i_q_op.amount[16:0], 15'd0};
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_THIN: begin
                                r_w <= sat(34'(r_w) - 34'(i_q_op.amount));
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_WIDE: begin
                                r_w <= sat(34'(r_w) + 34'(i_q_op.amount));
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_PUSH: begin
                                if (r_sp < DEPTH_V) r_sp <= r_sp + SP_W'(1);
                                r_state <= S_OUT;
                            end
                            tgi_pkg::K_POP: begin
                                if (r_sp == '0) r_state <= S_OUT;
                                else r_state <= S_POPRD;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_POPRD: begin
                    {r_x, r_y, r_hd, r_w, r_ring[0], r_ring[1], r_ring[2], r_head} <= r_rd;
                    r_sp <= r_sp - SP_W'(1);
                    r_state <= S_OUT;
                end
                S_CORDIC: begin
                    if (cs_done) begin
                        r_px <= 66'(r_op.amount) * 66'(cs_cos);
                        r_py <= -(66'(r_op.amount) * 66'(cs_sin));
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    r_x <= sat(34'(r_x) + w_rx[33:0]);
                    r_y <= sat(34'(r_y) + w_ry[33:0]);
                    if (r_op.kind == tgi_pkg::K_DRAW) begin
                        id = r_next;
                        slot = mod_n({1'b0, r_head}, 2'd3);
                        seen2 = (r_seen < 2'd3) ? r_seen + 2'd1 : r_seen;
                        hd2 = mod_n({1'b0, r_head} + 3'd1, w_n);
                        r_next <= r_next + NODE_ID_BITS'(1);
                        r_seen <= seen2;
                        r_ring[slot] <= id;
                        r_head <= hd2;
                        r_node_v <= 1'b1;
                        r_node_id <= tgi_pkg::ID_W'(id);
                        r_seg_v <= (seen2 >= w_n);
                        for (int k = 0; k < 3; k++) begin
                            logic [1:0] sl;
                            logic [NODE_ID_BITS-1:0] v;
                            sl = mod_n({1'b0, hd2} + 3'(k), w_n);
                            v = (sl == slot) ? id : r_ring[sl];
                            if (seen2 >= w_n && k < int'(w_n))
                                r_seg[k] <= tgi_pkg::ID_W'(v);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_data <= '{r_err, r_node_v, r_node_id, r_x, r_y, r_hd, r_w,
                                    r_seg_v, r_seg[0], r_seg[1], r_seg[2]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/turtle_graphics_interpreter.sv */
// Top level of the turtle graphics interpreter: APB registers, front and back.
// Depends on tgi_pkg, tgi_front, tgi_back.
//
//  channel | direction | handshake          | word
//  input   | in        | i_valid / o_stall  | i_data (kind, amount)
//  result  | out       | o_valid / i_stall  | o_data (one word per input word)
//  config  | in        | APB psel/penable   | start_x, start_y, start_heading, nps
//
// Moves run the 16-step iterative CORDIC, then the multiply and add states of the
// back end state machine; other words go straight to its output state, a pop by way of a stack read state.
// Reset is synchronous, active low; the stack memory is not cleared.
// A stalled result holds the back end; the front queue takes words until its
// two entries fill.
`default_nettype none
module turtle_graphics_interpreter #(
    parameter int STACK_DEPTH = tgi_pkg::STACK_DEPTH_DEF,
    parameter int NODE_ID_BITS = tgi_pkg::NODE_ID_BITS_DEF,
    parameter int MAX_SEG = tgi_pkg::MAX_SEG_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire tgi_pkg::t_in                i_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output tgi_pkg::t_out                    o_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tgi_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    logic signed [31:0] r_start_x, r_start_y;
    logic [31:0] r_start_hd;
    logic [1:0] r_nps;
    logic q_valid, q_pop, w_idle;
    tgi_pkg::t_op q_op;

    assign pready = 1'b1;

    // register write on access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0; r_start_y <= '0; r_start_hd <= '0; r_nps <= 2'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                tgi_pkg::R_START_X: r_start_x <= pwdata;
                tgi_pkg::R_START_Y: r_start_y <= pwdata;
                tgi_pkg::R_START_HD: r_start_hd <= pwdata;
                tgi_pkg::R_NPS: r_nps <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tgi_pkg::R_START_X: prdata = r_start_x;
            tgi_pkg::R_START_Y: prdata = r_start_y;
            tgi_pkg::R_START_HD: prdata = r_start_hd;
            default: prdata = {30'd0, r_nps};
        endcase
    end

    tgi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_q_valid(q_valid), .o_q_op(q_op), .i_q_pop(q_pop)
    );

    tgi_back #(.STACK_DEPTH(STACK_DEPTH), .NODE_ID_BITS(NODE_ID_BITS),
               .MAX_SEG(MAX_SEG)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_op(q_op),
        .o_q_pop(q_pop), .i_start_x(r_start_x), .i_start_y(r_start_y),
        .i_start_hd(r_start_hd), .i_nps(r_nps), .o_valid(o_valid),
        .i_stall(i_stall), .o_data(o_data), .o_idle(w_idle)
    );

`ifndef SYNTHESIS
    // a popped queue entry must exist
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("queue pop while empty");
    // an idle back end shows no pending result
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> !o_valid) else $error("idle with result pending");
    // error words carry no node
    a_err_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.error_code != tgi_pkg::E_OK) |-> !o_data.node_valid)
        else $error("node on error word");
`endif
endmodule
`default_nettype wire
